@@ hdl/upcc_pkg.sv @@
// Package for the URL path safety checker: character codes, limits and the
// per-byte class record shared by the datapath modules.
// No dependencies.
package upcc_pkg;

  // Widths of the configuration register and the path byte counter
  localparam int unsigned LenW   = 12;
  localparam int unsigned CountW = 13;
  localparam int unsigned OwedW  = 2;

  localparam logic [LenW-1:0]   MaxLenReset = 12'd2048;
  localparam logic [CountW-1:0] CountMax    = 13'h1fff;
  localparam logic [OwedW-1:0]  HexAfterPct = 2'd2;

  // Character codes
  localparam logic [7:0] CharCtrlLimit = 8'h20;
  localparam logic [7:0] CharDel       = 8'h7f;
  localparam logic [7:0] CharPct       = 8'h25;
  localparam logic [7:0] CharDot       = 8'h2e;
  localparam logic [7:0] CharSlash     = 8'h2f;
  localparam logic [7:0] CharDigit0    = 8'h30;
  localparam logic [7:0] CharDigit9    = 8'h39;
  localparam logic [7:0] CharUpperA    = 8'h41;
  localparam logic [7:0] CharUpperF    = 8'h46;
  localparam logic [7:0] CharUpperZ    = 8'h5a;
  localparam logic [7:0] CharLowerA    = 8'h61;
  localparam logic [7:0] CharLowerF    = 8'h66;
  localparam logic [7:0] CharLowerZ    = 8'h7a;

  // Classification of one path byte
  typedef struct packed {
    logic is_slash;
    logic is_dot;
    logic is_pct;
    logic is_hex;
    logic is_legal;
  } byte_class_t;

endpackage

@@ hdl/upcc_if.sv @@
// Channel interfaces for the URL path safety checker: path bytes in,
// verdicts out, and the configuration write channel.
// Depends on upcc_pkg.
interface upcc_byte_if;
  import upcc_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       last_byte;

  modport source (output valid, output path_byte, output last_byte, input ready);
  modport sink (input valid, input path_byte, input last_byte, output ready);
endinterface

interface upcc_verdict_if;
  logic valid;
  logic ready;
  logic path_safe;

  modport source (output valid, output path_safe, input ready);
  modport sink (input valid, input path_safe, output ready);
endinterface

interface upcc_cfg_if;
  import upcc_pkg::*;
  logic            valid;
  logic            ready;
  logic [LenW-1:0] max_path_length;

  modport source (output valid, output max_path_length, input ready);
  modport sink (input valid, input max_path_length, output ready);
endinterface

@@ hdl/upcc_byte_class.sv @@
// Byte classifier: decodes one path byte into the flags the rule checks use.
// Depends on upcc_pkg.
module upcc_byte_class
  import upcc_pkg::*;
(
  input  logic [7:0]  path_byte_i,
  output byte_class_t class_o
);

  logic is_digit;
  logic is_upper;
  logic is_lower;
  logic is_punct;
  logic is_ctrl;

  // Decode ranges
  assign is_digit = (path_byte_i >= CharDigit0) && (path_byte_i <= CharDigit9);
  assign is_upper = (path_byte_i >= CharUpperA) && (path_byte_i <= CharUpperZ);
  assign is_lower = (path_byte_i >= CharLowerA) && (path_byte_i <= CharLowerZ);
  assign is_ctrl  = (path_byte_i < CharCtrlLimit) || (path_byte_i == CharDel);

  // Unreserved, sub-delim and query punctuation plus fragment mark
  always_comb begin
    unique case (path_byte_i)
      8'h2d, 8'h5f, 8'h7e, CharDot, CharSlash, CharPct,
      8'h3f, 8'h26, 8'h3d, 8'h3a, 8'h40, 8'h21,
      8'h24, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2b,
      8'h2c, 8'h3b, 8'h23: is_punct = 1'b1;
      default:             is_punct = 1'b0;
    endcase
  end

  // Assemble flags
  always_comb begin
    class_o.is_slash = (path_byte_i == CharSlash);
    class_o.is_dot   = (path_byte_i == CharDot);
    class_o.is_pct   = (path_byte_i == CharPct);
    class_o.is_hex   = is_digit ||
                       ((path_byte_i >= CharUpperA) && (path_byte_i <= CharUpperF)) ||
                       ((path_byte_i >= CharLowerA) && (path_byte_i <= CharLowerF));
    class_o.is_legal = !is_ctrl && (is_digit || is_upper || is_lower || is_punct);
  end

endmodule

@@ hdl/upcc_path_track.sv @@
// Per-path state and rule evaluation: byte count, dot run, escape digits owed
// and sticky failure; produces the verdict on the last byte. Depends on upcc_pkg.
module upcc_path_track
  import upcc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  byte_class_t     class_i,
  input  logic            last_i,
  input  logic [LenW-1:0] max_len_i,
  output logic            safe_o
);

  logic [CountW-1:0] count_q, count_d, count_inc;
  logic              dot_q, dot_d, dot_nxt;
  logic [OwedW-1:0]  owed_q, owed_d, owed_nxt;
  logic              failed_q, failed_d;
  logic              fail;

  // Evaluate rules for the current byte
  always_comb begin
    fail      = failed_q;
    count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;
    if ((count_q == '0) && !class_i.is_slash) begin
      fail = 1'b1;
    end
    if (count_inc > {1'b0, max_len_i}) begin
      fail = 1'b1;
    end
    if (owed_q != '0) begin
      if (!class_i.is_hex) begin
        fail = 1'b1;
      end
      owed_nxt = owed_q - 1'b1;
      dot_nxt  = 1'b0;
    end else begin
      if (!class_i.is_legal) begin
        fail = 1'b1;
      end
      if (class_i.is_dot && dot_q) begin
        fail = 1'b1;
      end
      dot_nxt  = class_i.is_dot;
      owed_nxt = class_i.is_pct ? HexAfterPct : '0;
    end
    // An escape left open at the end fails the path
    safe_o = !(fail || (owed_nxt != '0));
  end

  // Advance or clear the per-path state
  always_comb begin
    count_d  = count_q;
    dot_d    = dot_q;
    owed_d   = owed_q;
    failed_d = failed_q;
    if (step_i) begin
      if (last_i) begin
        count_d  = '0;
        dot_d    = 1'b0;
        owed_d   = '0;
        failed_d = 1'b0;
      end else begin
        count_d  = count_inc;
        dot_d    = dot_nxt;
        owed_d   = owed_nxt;
        failed_d = fail;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      dot_q    <= 1'b0;
      owed_q   <= '0;
      failed_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      dot_q    <= dot_d;
      owed_q   <= owed_d;
      failed_q <= failed_d;
    end
  end

endmodule

@@ hdl/url_path_safety_checker_unit.sv @@
// Top level of the URL path safety checker: input register, byte classifier,
// path state tracker, verdict register and the length limit register.
// Depends on upcc_pkg, upcc_if, upcc_byte_class and upcc_path_track.

// Takes one path byte per cycle unless a held verdict stalls a last byte; a
// verdict (path_safe) is produced for the byte flagged last_byte and is
// presented from the verdict register once that byte has passed through the
// input register, to be taken when the output side is ready. A byte is held in the
// input register and is checked on its way into the state and verdict
// registers; a held verdict stalls only the last byte of the next path, other
// bytes keep flowing. max_path_length is written through the cfg channel,
// which is always ready; write it only between paths.
module url_path_safety_checker_unit
  import upcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  upcc_byte_if.sink             path_in,
  upcc_verdict_if.source        verdict_out,
  upcc_cfg_if.sink              cfg
);

  logic            in_vld_q, in_vld_d;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic            out_vld_q, out_vld_d;
  logic            out_safe_q;
  logic [LenW-1:0] max_len_q;
  logic            advance;
  logic            in_take;
  logic            safe;
  byte_class_t     byte_class;

  // Advance the held byte unless it would overwrite an untaken verdict
  assign advance = in_vld_q && (!in_last_q || !out_vld_q || verdict_out.ready);
  assign path_in.ready = !in_vld_q || advance;
  assign in_take = path_in.valid && path_in.ready;

  // Input register
  assign in_vld_d = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= path_in.path_byte;
      in_last_q <= path_in.last_byte;
    end
  end

  // Length limit register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg.valid && cfg.ready) begin
      max_len_q <= cfg.max_path_length;
    end
  end

  upcc_byte_class u_class (
    .path_byte_i (in_byte_q),
    .class_o     (byte_class)
  );

  upcc_path_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .class_i   (byte_class),
    .last_i    (in_last_q),
    .max_len_i (max_len_q),
    .safe_o    (safe)
  );

  // Verdict register: load on a last byte, drop once taken
  always_comb begin
    if (advance && in_last_q) begin
      out_vld_d = 1'b1;
    end else if (verdict_out.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_safe_q <= safe;
    end
  end

  assign verdict_out.valid     = out_vld_q;
  assign verdict_out.path_safe = out_safe_q;

endmodule

@@ hdl/upcc_checker.sv @@
// Port-level checker for the URL path safety checker and its bind to the
// top level. Depends on url_path_safety_checker_unit.
module upcc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_safe_i,
  input logic cfg_ready_i
);

  // Hold a verdict transaction until it is taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("verdict dropped before it was taken");

  // Keep the verdict stable while stalled
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_safe_i))
    else $error("verdict changed while stalled");

  // Accept bytes whenever the verdict side is free or draining
  a_in_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_i) |-> in_ready_i)
    else $error("input stalled while the output side was free");

  // Take configuration writes at any time
  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> cfg_ready_i)
    else $error("configuration channel not ready");

endmodule

bind url_path_safety_checker_unit upcc_checker u_upcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (path_in.ready),
  .out_valid_i (verdict_out.valid),
  .out_ready_i (verdict_out.ready),
  .out_safe_i  (verdict_out.path_safe),
  .cfg_ready_i (cfg.ready)
);

@@ test/testbench.sv @@
// Testbench for url_path_safety_checker_unit: streams request paths byte by
// byte, predicts each path verdict and checks it against the block.
// Depends on upcc_pkg, the upcc channel interfaces and the block itself.
module testbench;
  import upcc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 4;

  // Verdict predictor and store of pending verdicts
  class path_verdict_board;
    logic [LenW-1:0]   max_len;
    logic [CountW-1:0] byte_count;
    bit                prev_dot;
    bit [OwedW-1:0]    hex_owed;
    bit                failed;
    bit                pending_verdicts[$];
    int unsigned       n_errors;
    int unsigned       n_bytes;
    int unsigned       n_verdicts;
    int unsigned       n_safe;

    function new();
      max_len    = MaxLenReset;
      n_errors   = 0;
      n_bytes    = 0;
      n_verdicts = 0;
      n_safe     = 0;
      clear_path();
    endfunction

    function void clear_path();
      byte_count = '0;
      prev_dot   = 1'b0;
      hex_owed   = '0;
      failed     = 1'b0;
    endfunction

    function bit is_hex(bit [7:0] b);
      return (b >= CharDigit0 && b <= CharDigit9) || (b >= CharUpperA && b <= CharUpperF) ||
             (b >= CharLowerA && b <= CharLowerF);
    endfunction

    function bit is_allowed(bit [7:0] b);
      if ((b >= CharUpperA && b <= CharUpperZ) || (b >= CharLowerA && b <= CharLowerZ) ||
          (b >= CharDigit0 && b <= CharDigit9))
        return 1'b1;
      case (b)
        "-", "_", "~", CharDot, CharSlash, CharPct, "?", "&", "=", ":", "@", "!", "$", "'",
        "(", ")", "*", "+", ",", ";", "#": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Advance the path state by one accepted byte; queue a verdict on the last one
    function void note_byte(bit [7:0] b, bit is_last);
      bit fail;
      fail = failed;
      n_bytes++;
      if (byte_count == 0 && b != CharSlash) fail = 1'b1;
      if (byte_count != CountMax) byte_count++;
      if (byte_count > max_len) fail = 1'b1;
      if (hex_owed != 0) begin
        if (!is_hex(b)) fail = 1'b1;
        hex_owed--;
        prev_dot = 1'b0;
      end else begin
        if (b < CharCtrlLimit || b == CharDel) fail = 1'b1;
        if (!is_allowed(b)) fail = 1'b1;
        if (b == CharDot && prev_dot) fail = 1'b1;
        prev_dot = (b == CharDot);
        if (b == CharPct) hex_owed = HexAfterPct;
      end
      if (!is_last) begin
        failed = fail;
        return;
      end
      // an escape cut short by the end of the path fails it
      if (hex_owed != 0) fail = 1'b1;
      pending_verdicts.push_back(!fail);
      clear_path();
    endfunction

    // Compare one verdict transaction with the oldest pending verdict
    function void check_verdict(bit actual);
      bit want;
      n_verdicts++;
      if (actual) n_safe++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: path_safe %0b arrived with no path pending", $time, actual);
        n_errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (want != actual) begin
        $display("%0t: path_safe expected %0b, got %0b", $time, want, actual);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  upcc_byte_if    path_in ();
  upcc_verdict_if verdict_out ();
  upcc_cfg_if     cfg ();

  url_path_safety_checker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .path_in     (path_in),
    .verdict_out (verdict_out),
    .cfg         (cfg)
  );

  path_verdict_board board = new();

  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned idle_cycles = 0;
  bit          progress;
  string       plain_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_~?&=:@!$'()*+,;#";
  string       hex_chars   = "0123456789ABCDEFabcdef";

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the verdict side at random
  always @(posedge clk_i) begin
    verdict_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Sample both channels between edges; feed the board and watch for a hang
  always @(negedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (path_in.valid && path_in.ready) begin
        board.note_byte(path_in.path_byte, path_in.last_byte);
        progress = 1'b1;
      end
      if (verdict_out.valid && verdict_out.ready) begin
        board.check_verdict(verdict_out.path_safe);
        progress = 1'b1;
      end
      if (cfg.valid && cfg.ready) begin
        board.max_len = cfg.max_path_length;
        progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Drop valid and hold until every pending verdict has come back
  task automatic settle();
    path_in.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [LenW-1:0] value);
    bit fire;
    settle();
    cfg.valid           <= 1'b1;
    cfg.max_path_length <= value;
    do begin
      @(negedge clk_i);
      fire = cfg.ready;
      @(posedge clk_i);
    end while (!fire);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Present one byte after a random gap and hold it until accepted
  task automatic send_byte(input bit [7:0] b, input bit is_last);
    bit fire;
    while ($urandom_range(99) < gap_pct) begin
      path_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    path_in.valid     <= 1'b1;
    path_in.path_byte <= b;
    path_in.last_byte <= is_last;
    do begin
      @(negedge clk_i);
      fire = path_in.ready;
      @(posedge clk_i);
    end while (!fire);
  endtask

  task automatic send_path(input bit [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    bit [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_path(q);
  endtask

  // Long run of plain path characters behind a slash
  task automatic send_long(input int unsigned len);
    bit [7:0] q[$];
    q.push_back(CharSlash);
    while (q.size() < len) q.push_back(plain_chars[$urandom_range(plain_chars.len() - 1)]);
    send_path(q);
  endtask

  // Mostly well-formed path of at least a random 1 to cap bytes; some get broken on purpose
  function automatic void build_path(output bit [7:0] q[$], input int unsigned cap);
    int unsigned n;
    int unsigned pick;
    q = {};
    q.push_back(CharSlash);
    n = $urandom_range(cap, 1);
    while (q.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        q.push_back(plain_chars[$urandom_range(plain_chars.len() - 1)]);
      end else if (pick < 72) begin
        q.push_back(CharSlash);
      end else if (pick < 84) begin
        if (q[$] != CharDot) q.push_back(CharDot);
      end else begin
        q.push_back(CharPct);
        q.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
        q.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
      end
    end
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(5))
        0: q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
        1: q[0] = plain_chars[$urandom_range(plain_chars.len() - 1)];
        2: q.push_back(CharPct);
        3: begin
          q.push_back(CharDot);
          q.push_back(CharDot);
        end
        4: q[$urandom_range(q.size() - 1)] =
             $urandom_range(1) ? CharDel : 8'($urandom_range(31));
        default: begin
          q.push_back(CharPct);
          q.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
          if ($urandom_range(1)) q.push_back(8'($urandom_range(255)));
        end
      endcase
    end
  endfunction

  // One random phase under one length limit and one idling mix
  task automatic run_random(input int unsigned gap, input int unsigned stall,
                            input logic [LenW-1:0] limit_len, input int unsigned items);
    bit [7:0]    q[$];
    int unsigned sent;
    int unsigned cap;
    bit          paused;
    write_max_len(limit_len);
    gap_pct   = gap;
    stall_pct = stall;
    cap       = (limit_len != 0 && limit_len <= 16) ? limit_len + 4 : 20;
    sent      = 0;
    paused    = 1'b0;
    while (sent < items) begin
      build_path(q, cap);
      send_path(q);
      sent += q.size();
      // hold off the sender once mid-phase until the verdicts catch up
      if (!paused && sent >= items / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    clk_i                   = 1'b0;
    rst_ni                  = 1'b0;
    path_in.valid           = 1'b0;
    path_in.path_byte       = '0;
    path_in.last_byte       = 1'b0;
    verdict_out.ready       = 1'b0;
    cfg.valid               = 1'b0;
    cfg.max_path_length     = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed paths under the reset length limit
    send_text("/");
    send_text("a");
    send_text("/%2F");
    send_text("/%G1");
    send_text("/%4");
    send_text("/..");
    send_text("/%2e.");
    send_path('{CharSlash, 8'h00});
    send_path('{CharSlash, CharDel});
    send_path('{CharSlash, 8'hff});

    // Zero limit fails everything; a limit of one passes only a bare slash
    write_max_len('0);
    send_text("/");
    send_text("/a");
    write_max_len(12'd1);
    send_text("/");
    send_text("/a");

    // Small limit: exactly at it and one past it
    write_max_len(12'd3);
    send_long(3);
    send_long(4);

    run_random(0, 0, MaxLenReset, 150);
    run_random(58, 0, 12'd8, 150);
    run_random(0, 58, 12'd1, 100);
    run_random(22, 22, 12'd12, 150);
    run_random(0, 0, '0, 100);
    run_random(22, 22, 12'($urandom_range(4095, 1)), 150);
    run_random(0, 58, 12'd4095, 100);

    settle();
    board.n_errors += board.pending_verdicts.size();
    $display("Streamed %0d path bytes and checked %0d verdicts (%0d safe, %0d unsafe)",
             board.n_bytes, board.n_verdicts, board.n_safe, board.n_verdicts - board.n_safe);
    $display("across length limits from 0 to 4095 with mixed sender gaps and receiver stalls");
    if (board.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
